FILE: src/iodrt_pkg.sv
`default_nettype none
package iodrt_pkg;

  typedef enum logic [1:0] {
    RK_ACCEPT = 2'd0,
    RK_REJECT = 2'd1,
    RK_DONE   = 2'd2,
    RK_IDLE   = 2'd3
  } result_kind_e;

  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam int unsigned REG_DEVICE_ENABLE = 0;

  typedef struct packed {
    logic        kind;
    logic [9:0]  proc_id;
    logic [2:0]  device_index;
    logic [7:0]  op_tag;
    logic [15:0] duration;
  } req_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [9:0] done_proc_id;
    logic [2:0] done_device;
    logic [7:0] done_op;
    logic       last;
    logic       pending;
  } rsp_t;

  typedef struct packed {
    logic [9:0]  proc_id;
    logic [7:0]  op_tag;
    logic [15:0] duration;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_TRD,
    ST_TPROC,
    ST_TEMIT
  } state_e;

endpackage
`default_nettype wire

FILE: src/io_device_request_timer.sv
`default_nettype none
// io device request timer: per-device request fifos with tick-driven service
// input beat: start_i with req_i, taken at a rising edge where busy_o is low
//   kind submit: queues {proc_id, op_tag, duration} for device_index
//   kind tick: advances time by one tick for every device
// output beats: rsp_valid_o strobes for one cycle per result, rsp_o holds it
//   a submit gives one beat (accepted or rejected), registered from the
//   ST_SUB state; busy_o is high for one cycle
//   a tick first visits every device in turn (a request store read, ST_TRD,
//   then its update, ST_TPROC), then sends one completion beat per finished
//   device in index order, or one idle beat; last marks the final beat,
//   pending is only known after the device pass and is the same on all
// the block takes no new beat until it is back in idle; the single-port
//   store sets the length of the device pass
// all fifo entries live in one synchronous memory, one device region each;
// per-device head, count, active and timer state sit in flip-flops
// reset clears all control state at once; the store needs no clearing
// since only written slots are ever used
// the receiver cannot stall: results are pushed, never held
module io_device_request_timer #(
  parameter int unsigned NUM_DEVICES = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire iodrt_pkg::req_t   req_i,
  output logic                   busy_o,
  output logic                   rsp_valid_o,
  output iodrt_pkg::rsp_t        rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [0:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = DW + QW;

  iodrt_pkg::state_e state_q, state_d;

  logic [7:0]          enable_q;
  logic [QW-1:0]       head_q  [NUM_DEVICES];
  logic [CW-1:0]       count_q [NUM_DEVICES];
  logic [NUM_DEVICES-1:0] active_q;
  logic [15:0]         ticks_q [NUM_DEVICES];
  logic [9:0]          apid_q  [NUM_DEVICES];
  logic [7:0]          aop_q   [NUM_DEVICES];

  iodrt_pkg::entry_t   mem_q [NUM_DEVICES*QUEUE_DEPTH];
  iodrt_pkg::entry_t   rd_q;

  iodrt_pkg::req_t     req_q;
  logic [DW-1:0]       dev_q;
  logic [NUM_DEVICES-1:0] done_q;

  logic                rsp_valid_q;
  iodrt_pkg::rsp_t     rsp_q;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == 1'(iodrt_pkg::REG_DEVICE_ENABLE)) ? {24'd0, enable_q} : 32'd0;
  wire cfg_wr = psel && penable && pwrite && pready
             && (paddr == 1'(iodrt_pkg::REG_DEVICE_ENABLE));

  assign busy_o = (state_q != iodrt_pkg::ST_IDLE);
  wire take = start_i && !busy_o;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // submit check
  wire [DW-1:0] sdev = DW'(req_q.device_index);
  wire sdev_ok = (32'(req_q.device_index) < NUM_DEVICES);
  wire sub_ok = sdev_ok && enable_q[req_q.device_index]
             && (req_q.duration != 16'd0)
             && (32'(count_q[sdev]) < QUEUE_DEPTH);
  wire [QW:0] slot_sum = {1'b0, head_q[sdev]} + (QW+1)'(count_q[sdev]);
  logic [QW-1:0] slot;
  always_comb begin
    if (32'(slot_sum) >= QUEUE_DEPTH) slot = QW'(32'(slot_sum) - QUEUE_DEPTH);
    else slot = QW'(slot_sum);
  end
  logic [AW-1:0] wr_addr, rd_addr;
  always_comb begin
    wr_addr = AW'(32'(sdev) * QUEUE_DEPTH + 32'(slot));
    rd_addr = AW'(32'(dev_q) * QUEUE_DEPTH + 32'(head_q[dev_q]));
  end

  // tick per-device evaluation (after read)
  wire        starts = !active_q[dev_q] && (count_q[dev_q] != '0);
  wire        act    = active_q[dev_q] || starts;
  wire [15:0] tcur   = starts ? rd_q.duration : ticks_q[dev_q];
  wire [15:0] tdec   = (tcur != 16'd0) ? tcur - 16'd1 : tcur;
  wire        fin    = act && (tdec == 16'd0);
  wire        last_dev = (32'(dev_q) == NUM_DEVICES - 1);

  // pending from the current device state
  logic pend_now;
  always_comb begin
    pend_now = 1'b0;
    for (int d = 0; d < NUM_DEVICES; d++) begin
      if (active_q[d] || count_q[d] != '0) pend_now = 1'b1;
    end
  end
  wire pend_sub = pend_now || sub_ok;

  // completion beats leave after the device pass, lowest device first
  logic [DW-1:0] emit_idx;
  logic          emit_found;
  always_comb begin
    emit_idx   = '0;
    emit_found = 1'b0;
    for (int d = 0; d < NUM_DEVICES; d++) begin
      if (done_q[d] && !emit_found) begin
        emit_idx   = DW'(d);
        emit_found = 1'b1;
      end
    end
  end
  wire [NUM_DEVICES-1:0] done_rest = done_q & ~(NUM_DEVICES'(1) << emit_idx);
  wire emit_last = (done_rest == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iodrt_pkg::ST_IDLE: begin
        if (take) begin
          if (req_i.kind == iodrt_pkg::KIND_SUBMIT) state_d = iodrt_pkg::ST_SUB;
          else state_d = iodrt_pkg::ST_TRD;
        end
      end
      iodrt_pkg::ST_SUB:    state_d = iodrt_pkg::ST_IDLE;
      iodrt_pkg::ST_TRD:    state_d = iodrt_pkg::ST_TPROC;
      iodrt_pkg::ST_TPROC: begin
        if (!last_dev) state_d = iodrt_pkg::ST_TRD;
        else state_d = iodrt_pkg::ST_TEMIT;
      end
      iodrt_pkg::ST_TEMIT: begin
        if (!emit_found || emit_last) state_d = iodrt_pkg::ST_IDLE;
      end
      default:              state_d = iodrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= iodrt_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // request store: one write or one read a cycle
  always_ff @(posedge clk_i) begin
    if (state_q == iodrt_pkg::ST_SUB && sub_ok) begin
      mem_q[wr_addr] <= '{proc_id: req_q.proc_id, op_tag: req_q.op_tag,
                          duration: req_q.duration};
    end
    if (state_q == iodrt_pkg::ST_TRD) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take) req_q <= req_i;
    if (state_q == iodrt_pkg::ST_TPROC && starts) begin
      apid_q[dev_q] <= rd_q.proc_id;
      aop_q[dev_q]  <= rd_q.op_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 8'd0;
      active_q    <= '0;
      dev_q       <= '0;
      done_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      for (int d = 0; d < NUM_DEVICES; d++) begin
        head_q[d]  <= '0;
        count_q[d] <= '0;
        ticks_q[d] <= '0;
      end
    end else begin
      rsp_valid_q <= 1'b0;
      if (cfg_wr) enable_q <= pwdata[7:0];
      if (take) begin
        dev_q  <= '0;
        done_q <= '0;
      end
      unique case (state_q)
        iodrt_pkg::ST_SUB: begin
          if (sub_ok) count_q[sdev] <= count_q[sdev] + CW'(1);
          rsp_valid_q <= 1'b1;
          rsp_q <= '{result_kind: sub_ok ? iodrt_pkg::RK_ACCEPT : iodrt_pkg::RK_REJECT,
                     done_proc_id: '0, done_device: '0, done_op: '0,
                     last: 1'b1, pending: pend_sub};
        end
        iodrt_pkg::ST_TPROC: begin
          if (starts) begin
            count_q[dev_q] <= count_q[dev_q] - CW'(1);
            head_q[dev_q]  <= (32'(head_q[dev_q]) == QUEUE_DEPTH - 1) ? '0
                              : head_q[dev_q] + QW'(1);
          end
          if (act) ticks_q[dev_q] <= tdec;
          active_q[dev_q] <= act && !fin;
          if (fin) done_q[dev_q] <= 1'b1;
          if (!last_dev) dev_q <= dev_q + DW'(1);
        end
        iodrt_pkg::ST_TEMIT: begin
          rsp_valid_q <= 1'b1;
          if (emit_found) begin
            rsp_q <= '{result_kind: iodrt_pkg::RK_DONE, done_proc_id: apid_q[emit_idx],
                       done_device: 3'(emit_idx), done_op: aop_q[emit_idx],
                       last: emit_last, pending: pend_now};
          end else begin
            rsp_q <= '{result_kind: iodrt_pkg::RK_IDLE, done_proc_id: '0,
                       done_device: '0, done_op: '0, last: 1'b1, pending: pend_now};
          end
          done_q <= done_rest;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> busy_o)
    else $error("busy not raised after accept");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iodrt_pkg::ST_SUB) |=> rsp_valid_q)
    else $error("submit gave no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iodrt_pkg::ST_TEMIT) |=> rsp_valid_q)
    else $error("tick emit cycle gave no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (state_q == iodrt_pkg::ST_IDLE || state_q == iodrt_pkg::ST_TEMIT))
    else $error("result beat outside a result phase");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDEV  = 8;
  localparam int QDEPTH = 16;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  iodrt_pkg::req_t req_i = '0;
  logic            busy_o;
  logic            rsp_valid_o;
  iodrt_pkg::rsp_t rsp_o;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [0:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  io_device_request_timer uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // own copy of the device scheduler state
  logic [7:0]         enable_mask;
  iodrt_pkg::entry_t  fifo_mem [NDEV][QDEPTH];
  int                 fifo_head [NDEV];
  int                 fifo_count [NDEV];
  logic               dev_busy [NDEV];
  iodrt_pkg::entry_t  dev_job [NDEV];
  int                 dev_ticks [NDEV];

  iodrt_pkg::rsp_t    expected_beats [$];
  int          mismatches = 0;
  int          beats_seen = 0;
  int          completions_seen = 0;
  int          rejects_seen = 0;
  int          sender_idle_pct = 0;

  function automatic logic work_left();
    for (int d = 0; d < NDEV; d++) begin
      if (dev_busy[d] || fifo_count[d] != 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // predicts the result beats of one item and queues them
  function automatic void predict_item(iodrt_pkg::req_t r);
    iodrt_pkg::rsp_t beats [$];
    iodrt_pkg::rsp_t b;
    int   d;
    logic ok;
    logic p;
    if (r.kind == iodrt_pkg::KIND_SUBMIT) begin
      d = int'(r.device_index);
      ok = enable_mask[d] && r.duration != 0 && fifo_count[d] < QDEPTH;
      if (ok) begin
        fifo_mem[d][(fifo_head[d] + fifo_count[d]) % QDEPTH] =
          '{proc_id: r.proc_id, op_tag: r.op_tag, duration: r.duration};
        fifo_count[d]++;
      end
      b = '0;
      b.result_kind = ok ? iodrt_pkg::RK_ACCEPT : iodrt_pkg::RK_REJECT;
      beats.insert(beats.size(), b);
    end else begin
      for (d = 0; d < NDEV; d++) begin
        if (!dev_busy[d] && fifo_count[d] != 0) begin
          dev_job[d] = fifo_mem[d][fifo_head[d]];
          dev_ticks[d] = int'(dev_job[d].duration);
          fifo_head[d] = (fifo_head[d] + 1) % QDEPTH;
          fifo_count[d]--;
          dev_busy[d] = 1'b1;
        end
        if (!dev_busy[d]) continue;
        if (dev_ticks[d] != 0) dev_ticks[d]--;
        if (dev_ticks[d] != 0) continue;
        dev_busy[d] = 1'b0;
        b = '0;
        b.result_kind = iodrt_pkg::RK_DONE;
        b.done_proc_id = dev_job[d].proc_id;
        b.done_device = d[2:0];
        b.done_op = dev_job[d].op_tag;
        beats.insert(beats.size(), b);
      end
      if (beats.size() == 0) begin
        b = '0;
        b.result_kind = iodrt_pkg::RK_IDLE;
        beats.insert(beats.size(), b);
      end
    end
    p = work_left();
    foreach (beats[i]) begin
      beats[i].pending = p;
      beats[i].last = (i == beats.size() - 1);
      expected_beats.insert(expected_beats.size(), beats[i]);
    end
  endfunction

  // result checker: every strobe is compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      iodrt_pkg::rsp_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: expected none got %p", rsp_o);
      end else begin
        want = expected_beats.pop_front();
        if (want.result_kind == iodrt_pkg::RK_DONE) completions_seen++;
        if (want.result_kind == iodrt_pkg::RK_REJECT) rejects_seen++;
        if (rsp_o.result_kind !== want.result_kind ||
            rsp_o.done_proc_id !== want.done_proc_id ||
            rsp_o.done_device !== want.done_device ||
            rsp_o.done_op !== want.done_op ||
            rsp_o.last !== want.last || rsp_o.pending !== want.pending) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected %p got %p", want, rsp_o);
        end
      end
    end
  end

  // one beat into the block, with a random gap before it
  task automatic send_item(iodrt_pkg::req_t r);
    if (sender_idle_pct > 0) begin
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    // busy_o is read before the edge updates it, as the block sees it
    do @(posedge clk_i); while (busy_o);
    predict_item(r);
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_enable(logic [7:0] mask);
    // the register only changes with nothing in flight
    while (busy_o || expected_beats.size() != 0) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 1'(iodrt_pkg::REG_DEVICE_ENABLE);
    pwdata <= {24'd0, mask};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    enable_mask = mask;
    @(posedge clk_i);
    if (prdata[7:0] !== mask) begin
      mismatches++;
      if (mismatches <= 10)
        $display("enable readback: expected %h got %h", mask, prdata[7:0]);
    end
  endtask

  function automatic iodrt_pkg::req_t make_submit(int dev, int pid, int op, int dur);
    iodrt_pkg::req_t r;
    r.kind = iodrt_pkg::KIND_SUBMIT;
    r.proc_id = 10'(pid);
    r.device_index = 3'(dev);
    r.op_tag = 8'(op);
    r.duration = 16'(dur);
    return r;
  endfunction

  function automatic iodrt_pkg::req_t make_tick();
    iodrt_pkg::req_t r;
    r = iodrt_pkg::req_t'($bits(iodrt_pkg::req_t)'({$urandom, $urandom}));
    r.kind = iodrt_pkg::KIND_TICK;
    return r;
  endfunction

  // disabled devices, zero duration, full queue, extremes of every field
  task automatic test_directed();
    send_item(make_submit(3, 1023, 255, 1));
    write_enable(8'hff);
    send_item(make_submit(0, 0, 0, 0));
    send_item(make_submit(7, 1023, 255, 1));
    send_item(make_submit(0, 1023, 170, 65535));
    send_item(make_submit(5, 341, 85, 2));
    send_item(make_tick());
    send_item(make_tick());
    for (int i = 0; i < QDEPTH + 1; i++) send_item(make_submit(2, i, i, 1));
    wait_drained();
    // device turned off while it still holds work
    write_enable(8'h00);
    send_item(make_submit(2, 5, 5, 3));
    repeat (18) send_item(make_tick());
    wait_drained();
  endtask

  // mostly submits to random devices under a given enable mask, ticks between them
  task automatic test_random(int n, logic [7:0] mask, int idle);
    iodrt_pkg::req_t r;
    sender_idle_pct = idle;
    write_enable(mask);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40) r = make_tick();
      else begin
        r = iodrt_pkg::req_t'($bits(iodrt_pkg::req_t)'({$urandom, $urandom}));
        r.kind = iodrt_pkg::KIND_SUBMIT;
        case ($urandom_range(3))
          0: r.duration = 16'($urandom_range(1, 3));
          1: r.duration = 16'($urandom_range(0, 8));
          2: r.duration = 16'($urandom_range(1, 20));
          default: r.duration = 16'($urandom_range(1, 2));
        endcase
        if ($urandom_range(99) < 2) r.duration = 16'hffff;
      end
      send_item(r);
      if (i == n / 2) begin
        // hold off until everything expected has come
        while (expected_beats.size() != 0) @(posedge clk_i);
      end
    end
    wait_drained();
  endtask

  // a bounded run of ticks; very long requests may stay in service
  task automatic test_flush();
    sender_idle_pct = 0;
    for (int i = 0; i < 40 && work_left(); i++) send_item(make_tick());
    wait_drained();
  endtask

  initial begin
    enable_mask = '0;
    for (int d = 0; d < NDEV; d++) begin
      fifo_head[d] = 0;
      fifo_count[d] = 0;
      dev_busy[d] = 1'b0;
      dev_ticks[d] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120, 8'hff, 37);
    test_random(110, 8'h5a, 67);
    test_random(110, 8'h81, 0);
    test_flush();
    $display("covered %0d result beats, %0d completions, %0d rejects",
             beats_seen, completions_seen, rejects_seen);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("mismatches: %0d, beats left over: %0d", mismatches,
               expected_beats.size());
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
